// ===== rtl/mrrm_pkg.sv =====
// Shared constants, types and helper functions for the multi-range region matcher.
package mrrm_pkg;

	// Sizing
	localparam int REGIONS          = 64;
	localparam int CONTROLLER_SLOTS = 4;
	localparam int NDIMS            = 7 + CONTROLLER_SLOTS;
	localparam int NRUN             = 4 + CONTROLLER_SLOTS;
	localparam int REGION_W         = (REGIONS > 1) ? $clog2(REGIONS) : 1;
	localparam int CFG_SLOTS        = (CONTROLLER_SLOTS < 4) ? CONTROLLER_SLOTS : 4;
	localparam int BOUND_W          = 16;

	// Dimension numbering
	localparam int DIM_CHAN      = 0;
	localparam int DIM_KEY       = 1;
	localparam int DIM_VEL       = 2;
	localparam int DIM_FIRST_RUN = 3;
	localparam int DIM_SWITCH    = 6;
	localparam int RUN_FIRST_CC  = 4;

	// Request codes
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_SET   = 2'd1;
	localparam logic [1:0] REQ_CTRL  = 2'd2;
	localparam logic [1:0] REQ_QUERY = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] CFG_REGION_COUNT = 3'd0;
	localparam logic [2:0] CFG_SLOT_ZERO    = 3'd1;

	// Bound encodings
	localparam logic [7:0] HIGH_ANY  = 8'hFF;
	localparam logic [7:0] FULL_HIGH = 8'd127;
	localparam logic [7:0] FULL_LOW  = 8'd0;
	localparam logic [7:0] CHAN_LOW  = 8'd1;
	localparam logic [7:0] CHAN_HIGH = 8'd16;

	// Controller to datapath commands
	typedef struct packed {
		logic clear_step;
		logic load;
		logic set_run;
		logic ctrl_chg;
		logic scan_start;
		logic scan_step;
		logic finish;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic scan_last;
		logic count_zero;
	} sts_t;

	// Reset bound pair {low, high} of one dimension
	function automatic logic [BOUND_W-1:0] bound_reset(input int d);
		logic [BOUND_W-1:0] r;
		if (d == DIM_CHAN) begin
			r = {CHAN_LOW, CHAN_HIGH};
		end else if (d == DIM_SWITCH) begin
			r = {HIGH_ANY, HIGH_ANY};
		end else begin
			r = {FULL_LOW, FULL_HIGH};
		end
		return r;
	endfunction

endpackage

// ===== rtl/mrrm_ram.sv =====
// Generic single-port-write, registered-read RAM.
module mrrm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== rtl/mrrm_datapath.sv =====
// Datapath: bound memories, running values, config registers, scan compare and result regs.
module mrrm_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  mrrm_pkg::cmd_t      cmd,
	output mrrm_pkg::sts_t      sts,
	input  logic [5:0]          region_index,
	input  logic [3:0]          dim_index,
	input  logic signed [7:0]   range_low,
	input  logic signed [7:0]   range_high,
	input  logic [6:0]          controller_number,
	input  logic [6:0]          running_value,
	input  logic [4:0]          chan,
	input  logic [6:0]          note_key,
	input  logic [6:0]          velocity,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [6:0]          cfg_data,
	output logic                result_valid,
	output logic [5:0]          matched_region,
	output logic                match_valid,
	output logic                last
);

	localparam int RW = mrrm_pkg::REGION_W;

	// Configuration registers
	logic [6:0] count_q;
	logic [6:0] slot_q [mrrm_pkg::CFG_SLOTS];
	logic [6:0] slot_num [mrrm_pkg::CONTROLLER_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int s = 0; s < mrrm_pkg::CFG_SLOTS; s++) begin
				slot_q[s] <= 7'(s + 1);
			end
		end else if (cfg_we) begin
			if (cfg_index == mrrm_pkg::CFG_REGION_COUNT) begin
				count_q <= (cfg_data > 7'(mrrm_pkg::REGIONS)) ? 7'(mrrm_pkg::REGIONS) : cfg_data;
			end
			for (int s = 0; s < mrrm_pkg::CFG_SLOTS; s++) begin
				if (cfg_index == mrrm_pkg::CFG_SLOT_ZERO + 3'(s)) begin
					slot_q[s] <= cfg_data;
				end
			end
		end
	end

	// Slots past the configurable ones watch fixed controller numbers
	for (genvar s = 0; s < mrrm_pkg::CONTROLLER_SLOTS; s++) begin : g_slot
		if (s < mrrm_pkg::CFG_SLOTS) begin : g_reg
			assign slot_num[s] = slot_q[s];
		end else begin : g_fix
			assign slot_num[s] = 7'(s + 1);
		end
	end

	// Running values: aftertouch, program, switch, controller slots
	logic [6:0] running_q [mrrm_pkg::NRUN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mrrm_pkg::NRUN; i++) begin
				running_q[i] <= '0;
			end
		end else begin
			if (cmd.set_run) begin
				for (int i = 0; i < mrrm_pkg::NRUN; i++) begin
					if (dim_index == 4'(i + mrrm_pkg::DIM_FIRST_RUN)) begin
						running_q[i] <= running_value;
					end
				end
			end
			if (cmd.ctrl_chg) begin
				for (int s = 0; s < mrrm_pkg::CONTROLLER_SLOTS; s++) begin
					if (slot_num[s] == controller_number) begin
						running_q[mrrm_pkg::RUN_FIRST_CC + s] <= running_value;
					end
				end
			end
		end
	end

	// Query operands latched at query accept
	logic [4:0] qchan_q;
	logic [6:0] qkey_q;
	logic [6:0] qvel_q;

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			qchan_q <= chan;
			qkey_q  <= note_key;
			qvel_q  <= velocity;
		end
	end

	// Clear sweep and scan address counters
	logic [RW-1:0] clr_addr_q;
	logic [RW-1:0] scan_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			scan_addr_q <= '0;
		end else begin
			if (cmd.clear_step) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.scan_start) begin
				scan_addr_q <= '0;
			end else if (cmd.scan_step) begin
				scan_addr_q <= scan_addr_q + 1'b1;
			end
		end
	end

	assign sts.clr_last   = (clr_addr_q == RW'(mrrm_pkg::REGIONS - 1));
	assign sts.scan_last  = ((7'(scan_addr_q) + 7'd1) == count_q);
	assign sts.count_zero = (count_q == '0);

	// Bound memories, one per dimension, all read at the scan address
	logic load_ok;
	logic [RW-1:0] wr_addr;
	logic [mrrm_pkg::BOUND_W-1:0] rd_data [mrrm_pkg::NDIMS];
	logic [mrrm_pkg::NDIMS-1:0] dim_ok;
	logic [7:0] vals [mrrm_pkg::NDIMS];

	assign load_ok = cmd.load && ({1'b0, region_index} < 7'(mrrm_pkg::REGIONS))
		&& ({1'b0, dim_index} < 5'(mrrm_pkg::NDIMS));
	assign wr_addr = cmd.clear_step ? clr_addr_q : region_index[RW-1:0];

	for (genvar d = 0; d < mrrm_pkg::NDIMS; d++) begin : g_dim
		logic we;
		logic [mrrm_pkg::BOUND_W-1:0] wdata;
		logic signed [8:0] lo9;
		logic signed [8:0] hi9;
		logic signed [8:0] v9;

		assign we    = cmd.clear_step || (load_ok && (dim_index == 4'(d)));
		assign wdata = cmd.clear_step ? mrrm_pkg::bound_reset(d) : {range_low, range_high};

		mrrm_ram #(
			.WIDTH(mrrm_pkg::BOUND_W),
			.DEPTH(mrrm_pkg::REGIONS)
		) u_bound_ram (
			.clk    (clk),
			.we     (we),
			.wr_addr(wr_addr),
			.wr_data(wdata),
			.rd_addr(scan_addr_q),
			.rd_data(rd_data[d])
		);

		// Value under test for this dimension
		if (d == mrrm_pkg::DIM_CHAN) begin : g_chan
			assign vals[d] = {3'b000, qchan_q};
		end else if (d == mrrm_pkg::DIM_KEY) begin : g_key
			assign vals[d] = {1'b0, qkey_q};
		end else if (d == mrrm_pkg::DIM_VEL) begin : g_vel
			assign vals[d] = {1'b0, qvel_q};
		end else begin : g_run
			assign vals[d] = {1'b0, running_q[d - mrrm_pkg::DIM_FIRST_RUN]};
		end

		// Signed inclusive compare; an all-ones high bound reads as the full high
		assign lo9 = {rd_data[d][15], rd_data[d][15:8]};
		assign hi9 = (rd_data[d][7:0] == mrrm_pkg::HIGH_ANY) ? {1'b0, mrrm_pkg::FULL_HIGH}
			: {rd_data[d][7], rd_data[d][7:0]};
		assign v9  = {1'b0, vals[d]};
		assign dim_ok[d] = (lo9 <= v9) && (v9 <= hi9);
	end

	// Read-data stage tag
	logic rd_valid_s1;
	logic [RW-1:0] region_s1;
	logic hit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan_step;
		end
	end

	always_ff @(posedge clk) begin
		region_s1 <= scan_addr_q;
	end

	assign hit_s1 = rd_valid_s1 && (&dim_ok);

	// One hit is held back so the final one can carry last
	logic pend_vld_q;
	logic [RW-1:0] pend_region_q;
	logic out_stb_q;
	logic [5:0] out_region_q;
	logic out_match_q;
	logic out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			out_stb_q  <= 1'b0;
		end else begin
			out_stb_q <= (hit_s1 && pend_vld_q) || cmd.finish;
			if (cmd.scan_start) begin
				pend_vld_q <= 1'b0;
			end else if (hit_s1) begin
				pend_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit_s1) begin
			pend_region_q <= region_s1;
		end
		if (cmd.finish) begin
			out_region_q <= pend_vld_q ? 6'(pend_region_q) : '0;
			out_match_q  <= pend_vld_q;
			out_last_q   <= 1'b1;
		end else begin
			out_region_q <= 6'(pend_region_q);
			out_match_q  <= 1'b1;
			out_last_q   <= 1'b0;
		end
	end

	assign result_valid   = out_stb_q;
	assign matched_region = out_region_q;
	assign match_valid    = out_match_q;
	assign last           = out_last_q;

	// A no-match beat always closes its query
	a_nomatch_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_stb_q && !out_match_q |-> out_last_q)
		else $error("no-match beat without last");

	// Every finish produces exactly one closing beat
	a_finish_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_stb_q && out_last_q)
		else $error("finish did not produce final beat");

	// A hit and the closing beat never compete for the output register
	a_hit_vs_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!(hit_s1 && cmd.finish))
		else $error("scan hit collides with finish");

endmodule

// ===== rtl/mrrm_ctrl.sv =====
// Controller: clear sweep, item decode, region scan sequencing.
module mrrm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     req_type,
	input  mrrm_pkg::sts_t sts,
	output mrrm_pkg::cmd_t cmd,
	output logic           busy
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					unique case (req_type)
						mrrm_pkg::REQ_LOAD: cmd.load     = 1'b1;
						mrrm_pkg::REQ_SET:  cmd.set_run  = 1'b1;
						mrrm_pkg::REQ_CTRL: cmd.ctrl_chg = 1'b1;
						mrrm_pkg::REQ_QUERY: begin
							cmd.scan_start = 1'b1;
							state_d = sts.count_zero ? ST_FINISH : ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// A query either scans or, with no regions, closes at once
	a_query_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |=> (state_q == ST_SCAN) || (state_q == ST_FINISH))
		else $error("query accept did not enter scan");

	// The read stage drains in the drain state, which follows the scan, before the closing beat
	a_drain_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> $past(state_q) == ST_SCAN)
		else $error("drain entered out of order");

endmodule

// ===== rtl/multi_range_region_match.sv =====
// Top level of the multi-range region matcher: controller plus datapath.
//
// After reset the block sweeps the bound memories to their full-range defaults, one region
// per cycle, with busy high; configuration writes are taken meanwhile. Load, set and
// controller change items leave the controller idle, so the next item may start on the
// following cycle. A query scans the regions (with no regions it skips the scan and the
// drain): the scan reads one region from the per-dimension bound memories each cycle and
// checks all eleven dimensions in parallel, then the drain state empties the memory read
// stage and the finish state issues the final beat. Results appear on result_valid for one
// cycle each, in region order; each hit is held until the next hit or the end of the scan so
// the final one can carry last, which means the last beat shows in the cycle after the
// finish cycle. A query with no hit gives a single beat with match_valid low. The receiver
// cannot stall, so every beat must be taken when shown. cfg_ready is always high.
module multi_range_region_match (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        req_type,
	input  logic [5:0]        region_index,
	input  logic [3:0]        dim_index,
	input  logic signed [7:0] range_low,
	input  logic signed [7:0] range_high,
	input  logic [6:0]        controller_number,
	input  logic [6:0]        running_value,
	input  logic [4:0]        chan,
	input  logic [6:0]        note_key,
	input  logic [6:0]        velocity,
	output logic              result_valid,
	output logic [5:0]        matched_region,
	output logic              match_valid,
	output logic              last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [6:0]        cfg_data
);

	mrrm_pkg::cmd_t cmd;
	mrrm_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	mrrm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_type(req_type),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (busy)
	);

	mrrm_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.region_index     (region_index),
		.dim_index        (dim_index),
		.range_low        (range_low),
		.range_high       (range_high),
		.controller_number(controller_number),
		.running_value    (running_value),
		.chan             (chan),
		.note_key         (note_key),
		.velocity         (velocity),
		.cfg_we           (cfg_valid & cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.result_valid     (result_valid),
		.matched_region   (matched_region),
		.match_valid      (match_valid),
		.last             (last)
	);

endmodule
